FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define PS2SC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property that must hold in the cycle after a condition is seen.
`define PS2SC_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: rtl/ps2sc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ps2sc_pkg;

    localparam int CMD_QUEUE_DEPTH_DEF = 32;

    // Two entries are enough to keep the front busy while the back emits a result.
    localparam int OPQ_DEPTH = 2;
    localparam int OPQ_AW    = 1;
    localparam int OPQ_CW    = $clog2(OPQ_DEPTH + 1);

    localparam logic [7:0] SC_TAB         = 8'h0F;
    localparam logic [7:0] SC_LSHIFT_MAKE = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BRK  = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BRK  = 8'hB6;
    localparam logic [7:0] SC_CAPS_LOCK   = 8'h3A;
    localparam logic [7:0] SC_NUM_LOCK    = 8'h45;
    localparam logic [7:0] SC_SCROLL_LOCK = 8'h46;
    localparam logic [7:0] SC_F1          = 8'h3B;
    localparam logic [7:0] SC_F11         = 8'h57;
    localparam logic [7:0] KB_ACK         = 8'hFA;
    localparam logic [7:0] KB_RESEND      = 8'hFE;
    localparam logic [7:0] KB_LED_CMD     = 8'hED;

    localparam logic [7:0] EVT_TAB   = 8'd0;
    localparam logic [7:0] EVT_BREAK = 8'd1;
    localparam logic [7:0] EVT_RAISE = 8'd2;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_CASE    = 8'h20;

    localparam logic [2:0] LED_CAPS   = 3'b100;
    localparam logic [2:0] LED_NUM    = 3'b010;
    localparam logic [2:0] LED_SCROLL = 3'b001;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_CMD   = 2'd1,
        KIND_EVENT = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PUSH,
        BK_DIRECT,
        BK_SEND
    } t_back_state;

    // One classified scan code handed from the front to the back.
    typedef struct packed {
        logic       has_res;
        t_kind      res_kind;
        logic [7:0] res_value;
        logic       is_ack;
        logic       is_resend;
        logic       push_start;
        logic [2:0] start_leds;
        logic       push_lock;
        logic [2:0] lock_leds;
    } t_op;

    function automatic logic [7:0] plain_char(input logic [6:0] code);
        logic [7:0] ch;
        ch = 8'h00;
        case (code)
            7'h02: ch = 8'h31;
            7'h03: ch = 8'h32;
            7'h04: ch = 8'h33;
            7'h05: ch = 8'h34;
            7'h06: ch = 8'h35;
            7'h07: ch = 8'h36;
            7'h08: ch = 8'h37;
            7'h09: ch = 8'h38;
            7'h0A: ch = 8'h39;
            7'h0B: ch = 8'h30;
            7'h0C: ch = 8'h2D;
            7'h0D: ch = 8'h5E;
            7'h0E: ch = 8'h08;
            7'h10: ch = 8'h51;
            7'h11: ch = 8'h57;
            7'h12: ch = 8'h45;
            7'h13: ch = 8'h52;
            7'h14: ch = 8'h54;
            7'h15: ch = 8'h59;
            7'h16: ch = 8'h55;
            7'h17: ch = 8'h49;
            7'h18: ch = 8'h4F;
            7'h19: ch = 8'h50;
            7'h1A: ch = 8'h40;
            7'h1B: ch = 8'h5B;
            7'h1C: ch = 8'h0A;
            7'h1E: ch = 8'h41;
            7'h1F: ch = 8'h53;
            7'h20: ch = 8'h44;
            7'h21: ch = 8'h46;
            7'h22: ch = 8'h47;
            7'h23: ch = 8'h48;
            7'h24: ch = 8'h4A;
            7'h25: ch = 8'h4B;
            7'h26: ch = 8'h4C;
            7'h27: ch = 8'h3B;
            7'h28: ch = 8'h3A;
            7'h2B: ch = 8'h5D;
            7'h2C: ch = 8'h5A;
            7'h2D: ch = 8'h58;
            7'h2E: ch = 8'h43;
            7'h2F: ch = 8'h56;
            7'h30: ch = 8'h42;
            7'h31: ch = 8'h4E;
            7'h32: ch = 8'h4D;
            7'h33: ch = 8'h2C;
            7'h34: ch = 8'h2E;
            7'h35: ch = 8'h2F;
            7'h37: ch = 8'h2A;
            7'h39: ch = 8'h20;
            7'h47: ch = 8'h37;
            7'h48: ch = 8'h38;
            7'h49: ch = 8'h39;
            7'h4A: ch = 8'h2D;
            7'h4B: ch = 8'h34;
            7'h4C: ch = 8'h35;
            7'h4D: ch = 8'h36;
            7'h4E: ch = 8'h2B;
            7'h4F: ch = 8'h31;
            7'h50: ch = 8'h32;
            7'h51: ch = 8'h33;
            7'h52: ch = 8'h30;
            7'h53: ch = 8'h2E;
            7'h73: ch = 8'h5C;
            7'h7D: ch = 8'h5C;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // The shifted layout differs from the plain one only on the entries listed here.
    function automatic logic [7:0] shifted_char(input logic [6:0] code);
        logic [7:0] ch;
        ch = 8'h00;
        case (code)
            7'h02: ch = 8'h21;
            7'h03: ch = 8'h22;
            7'h04: ch = 8'h23;
            7'h05: ch = 8'h24;
            7'h06: ch = 8'h25;
            7'h07: ch = 8'h26;
            7'h08: ch = 8'h27;
            7'h09: ch = 8'h28;
            7'h0A: ch = 8'h29;
            7'h0B: ch = 8'h7E;
            7'h0C: ch = 8'h3D;
            7'h0D: ch = 8'h7E;
            7'h1A: ch = 8'h60;
            7'h1B: ch = 8'h7B;
            7'h27: ch = 8'h2B;
            7'h28: ch = 8'h2A;
            7'h2B: ch = 8'h7D;
            7'h33: ch = 8'h3C;
            7'h34: ch = 8'h3E;
            7'h35: ch = 8'h3F;
            7'h73: ch = 8'h5F;
            7'h7D: ch = 8'h7C;
            default: ch = plain_char(code);
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ps2sc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ps2sc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/ps2sc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ps2sc_front
    import ps2sc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_scan_code,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_initial_leds,
    input  wire logic       i_opq_full,
    output logic            o_opq_push,
    output t_op             o_op
);

    logic [2:0] r_init_leds;
    logic [1:0] r_shift;
    logic [1:0] n_shift;
    logic [2:0] r_leds;
    logic [2:0] n_leds;
    logic       r_started;

    logic [2:0] leds_cur;
    logic       shift_any;
    logic [7:0] ch_raw;
    logic [7:0] ch;
    logic [2:0] toggle;
    logic       accept;
    t_op        op;

    assign accept      = i_in_valid && !i_opq_full;
    assign o_in_ready  = !i_opq_full;
    assign o_cfg_ready = 1'b1;

    // Before the first byte the LEDs come from the configuration register.
    assign leds_cur  = r_started ? r_leds : r_init_leds;
    assign shift_any = |r_shift;

    always_comb begin
        ch_raw = 8'h00;
        if (!i_scan_code[7]) begin
            ch_raw = shift_any ? shifted_char(i_scan_code[6:0]) : plain_char(i_scan_code[6:0]);
        end
        ch = ch_raw;
        if (ch_raw >= CHAR_UPPER_A && ch_raw <= CHAR_UPPER_Z && (leds_cur[2] == shift_any)) begin
            ch = ch_raw + CHAR_CASE;
        end
    end

    always_comb begin
        toggle = 3'b000;
        if (i_scan_code == SC_CAPS_LOCK) begin
            toggle = LED_CAPS;
        end else if (i_scan_code == SC_NUM_LOCK) begin
            toggle = LED_NUM;
        end else if (i_scan_code == SC_SCROLL_LOCK) begin
            toggle = LED_SCROLL;
        end
    end

    always_comb begin
        op            = '0;
        op.res_kind   = KIND_CHAR;
        op.res_value  = ch;
        op.has_res    = 1'b0;
        // A scan code with a table entry never is one of the event keys.
        if (ch != 8'h00) begin
            op.has_res = 1'b1;
        end else if (i_scan_code == SC_TAB) begin
            op.has_res   = 1'b1;
            op.res_kind  = KIND_EVENT;
            op.res_value = EVT_TAB;
        end else if (i_scan_code == SC_F1 && shift_any) begin
            op.has_res   = 1'b1;
            op.res_kind  = KIND_EVENT;
            op.res_value = EVT_BREAK;
        end else if (i_scan_code == SC_F11) begin
            op.has_res   = 1'b1;
            op.res_kind  = KIND_EVENT;
            op.res_value = EVT_RAISE;
        end
        op.is_ack     = (i_scan_code == KB_ACK);
        op.is_resend  = (i_scan_code == KB_RESEND);
        op.push_start = !r_started;
        op.start_leds = r_init_leds;
        op.push_lock  = |toggle;
        op.lock_leds  = leds_cur ^ toggle;
    end

    always_comb begin
        n_shift = r_shift;
        if (i_scan_code == SC_LSHIFT_MAKE) begin
            n_shift[0] = 1'b1;
        end
        if (i_scan_code == SC_RSHIFT_MAKE) begin
            n_shift[1] = 1'b1;
        end
        if (i_scan_code == SC_LSHIFT_BRK) begin
            n_shift[0] = 1'b0;
        end
        if (i_scan_code == SC_RSHIFT_BRK) begin
            n_shift[1] = 1'b0;
        end
        n_leds = leds_cur ^ toggle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_leds <= 3'b000;
            r_shift     <= 2'b00;
            r_leds      <= 3'b000;
            r_started   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_init_leds <= i_cfg_initial_leds;
            end
            if (accept) begin
                r_shift   <= n_shift;
                r_leds    <= n_leds;
                r_started <= 1'b1;
            end
        end
    end

    assign o_opq_push = accept;
    assign o_op       = op;

endmodule

`default_nettype wire

FILE: rtl/ps2sc_op_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module ps2sc_op_fifo
    import ps2sc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_op  i_op,
    output logic      o_full,
    input  wire logic i_pop,
    output t_op       o_op,
    output logic      o_empty
);

    t_op               r_mem [OPQ_DEPTH];
    logic [OPQ_AW-1:0] r_wr_ptr;
    logic [OPQ_AW-1:0] r_rd_ptr;
    logic [OPQ_CW-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == OPQ_CW'(OPQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == OPQ_AW'(OPQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == OPQ_AW'(OPQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ps2sc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ps2sc_back
    import ps2sc_pkg::*;
#(
    parameter int CMD_QUEUE_DEPTH = CMD_QUEUE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_opq_empty,
    input  wire t_op        i_op,
    output logic            o_opq_pop,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_value,
    output logic            o_last
);

    localparam int AW = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(CMD_QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;

    t_back_state r_state;
    t_back_state n_state;
    t_op         r_op;
    t_op         n_op;
    logic [3:0]  r_pend;
    logic [3:0]  n_pend;
    logic [AW-1:0] r_head;
    logic [AW-1:0] n_head;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic        r_awaiting;
    logic        n_awaiting;
    logic [7:0]  r_sent;
    logic [7:0]  n_sent;

    logic        r_out_valid;
    t_kind       r_out_kind;
    logic [7:0]  r_out_value;
    logic        r_out_last;

    logic        out_free;
    logic        out_load;
    t_kind       out_kind;
    logic [7:0]  out_value;
    logic        out_last;

    logic        q_full;
    logic [SW-1:0] tail_sum;
    logic [SW-1:0] tail_wrap;
    logic [AW-1:0] tail;
    logic [7:0]  push_byte;
    logic        ram_we;
    logic [7:0]  ram_rdata;

    logic        awaiting_eff;
    logic        deq;
    logic        has_direct;
    t_kind       direct_kind;
    logic [7:0]  direct_value;

    assign out_free = !r_out_valid || i_out_ready;
    assign q_full   = (r_count == CW'(CMD_QUEUE_DEPTH));

    // Head plus count stays below twice the depth, so one subtract wraps it.
    assign tail_sum  = SW'(r_head) + SW'(r_count);
    assign tail_wrap = (tail_sum >= SW'(CMD_QUEUE_DEPTH)) ? tail_sum - SW'(CMD_QUEUE_DEPTH)
                                                          : tail_sum;
    assign tail      = tail_wrap[AW-1:0];

    // Pending pushes in order: start command, start LEDs, lock command, lock LEDs.
    always_comb begin
        if (r_pend[0]) begin
            push_byte = KB_LED_CMD;
        end else if (r_pend[1]) begin
            push_byte = {5'b00000, r_op.start_leds};
        end else if (r_pend[2]) begin
            push_byte = KB_LED_CMD;
        end else begin
            push_byte = {5'b00000, r_op.lock_leds};
        end
    end

    assign awaiting_eff = r_awaiting && !r_op.is_ack;
    assign deq          = (r_count != '0) && !awaiting_eff;

    always_comb begin
        has_direct   = r_op.has_res;
        direct_kind  = r_op.res_kind;
        direct_value = r_op.res_value;
        if (!r_op.has_res && r_op.is_resend && r_awaiting) begin
            has_direct   = 1'b1;
            direct_kind  = KIND_CMD;
            direct_value = r_sent;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_opq_empty) begin
                    n_state = (i_op.push_start || i_op.push_lock) ? BK_PUSH : BK_DIRECT;
                end
            end
            BK_PUSH: begin
                if ((r_pend & (r_pend - 4'd1)) == 4'd0) begin
                    n_state = BK_DIRECT;
                end
            end
            BK_DIRECT: begin
                if (!has_direct || out_free) begin
                    n_state = deq ? BK_SEND : BK_IDLE;
                end
            end
            BK_SEND: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_opq_pop  = 1'b0;
        ram_we     = 1'b0;
        out_load   = 1'b0;
        out_kind   = KIND_CMD;
        out_value  = ram_rdata;
        out_last   = 1'b1;
        n_op       = r_op;
        n_pend     = r_pend;
        n_head     = r_head;
        n_count    = r_count;
        n_awaiting = r_awaiting;
        n_sent     = r_sent;
        case (r_state)
            BK_IDLE: begin
                if (!i_opq_empty) begin
                    o_opq_pop = 1'b1;
                    n_op      = i_op;
                    n_pend    = {i_op.push_lock, i_op.push_lock,
                                 i_op.push_start, i_op.push_start};
                end
            end
            BK_PUSH: begin
                n_pend = r_pend & (r_pend - 4'd1);
                // A byte that finds the queue full is dropped.
                if (!q_full) begin
                    ram_we  = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            BK_DIRECT: begin
                n_awaiting = awaiting_eff;
                if (has_direct && out_free) begin
                    out_load  = 1'b1;
                    out_kind  = direct_kind;
                    out_value = direct_value;
                    out_last  = !deq;
                end
            end
            BK_SEND: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    n_sent     = ram_rdata;
                    n_head     = (r_head == AW'(CMD_QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    n_count    = r_count - 1'b1;
                    n_awaiting = 1'b1;
                end
            end
            default: begin
                n_pend = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_pend      <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_awaiting  <= 1'b0;
            r_sent      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pend     <= n_pend;
            r_head     <= n_head;
            r_count    <= n_count;
            r_awaiting <= n_awaiting;
            r_sent     <= n_sent;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
        if (out_load) begin
            r_out_kind  <= out_kind;
            r_out_value <= out_value;
            r_out_last  <= out_last;
        end
    end

    // The read port always points at the head; its read data is registered.
    ps2sc_ram #(
        .WIDTH (8),
        .DEPTH (CMD_QUEUE_DEPTH),
        .AW    (AW)
    ) u_cmd_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (tail),
        .i_wdata (push_byte),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_value     = r_out_value;
    assign o_last      = r_out_last;

endmodule

`default_nettype wire

FILE: rtl/ps2_scancode_to_char_with_led_cmd.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Handshake                  Payload
// in       in   i_in_valid / o_in_ready    i_scan_code
// out      out  o_out_valid / i_out_ready  o_kind, o_value, o_last
// cfg      in   i_cfg_valid / o_cfg_ready  i_cfg_initial_leds
//
// The front takes one scan code beat per cycle into a two-entry op queue while it is not full.
// For each byte the back fetches the op, writes its LED bytes to the command memory
// (up to four on the first byte), emits at most one result, and may then send a queued
// command byte (registered read of the command memory).
// Reset is synchronous and clears control state; the command memory is not cleared.
// A result waiting in the output register stalls the back; the front keeps taking
// beats until the op queue is full.

module ps2_scancode_to_char_with_led_cmd
    import ps2sc_pkg::*;
#(
    parameter int CMD_QUEUE_DEPTH = CMD_QUEUE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_scan_code,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_value,
    output logic            o_last,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_initial_leds
);

    logic opq_push;
    logic opq_full;
    logic opq_pop;
    logic opq_empty;
    t_op  front_op;
    t_op  back_op;

    ps2sc_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_scan_code        (i_scan_code),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_initial_leds (i_cfg_initial_leds),
        .i_opq_full         (opq_full),
        .o_opq_push         (opq_push),
        .o_op               (front_op)
    );

    ps2sc_op_fifo u_opq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (opq_push),
        .i_op    (front_op),
        .o_full  (opq_full),
        .i_pop   (opq_pop),
        .o_op    (back_op),
        .o_empty (opq_empty)
    );

    ps2sc_back #(
        .CMD_QUEUE_DEPTH (CMD_QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_opq_empty (opq_empty),
        .i_op        (back_op),
        .o_opq_pop   (opq_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_kind      (o_kind),
        .o_value     (o_value),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

FILE: rtl/ps2sc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ps2sc_checker
    import ps2sc_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [1:0] o_kind,
    input wire logic [7:0] o_value,
    input wire logic       o_last
);

    `PS2SC_ASSERT_NEXT(a_out_valid_holds, o_out_valid && !i_out_ready, o_out_valid,
        "result beat dropped while stalled")
    `PS2SC_ASSERT_NEXT(a_out_payload_holds, o_out_valid && !i_out_ready,
        $stable({o_kind, o_value, o_last}), "result payload changed while stalled")
    `PS2SC_ASSERT(a_kind_legal, o_out_valid |-> (o_kind == KIND_CHAR || o_kind == KIND_CMD
        || o_kind == KIND_EVENT), "result kind out of range")
    `PS2SC_ASSERT(a_event_legal, (o_out_valid && o_kind == KIND_EVENT) |-> (o_value <= EVT_RAISE),
        "window event code out of range")
    `PS2SC_ASSERT(a_char_nonzero, (o_out_valid && o_kind == KIND_CHAR) |-> (o_value != 8'h00),
        "character result with a zero code")

endmodule

bind ps2_scancode_to_char_with_led_cmd ps2sc_checker u_ps2sc_checker (.*);

`default_nettype wire

FILE: test/ps2_scancode_to_char_with_led_cmd_tb.sv
`timescale 1ns / 1ps

module ps2_scancode_to_char_with_led_cmd_tb;
    import ps2sc_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
        logic       last;
    } t_key_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_scan_code = 8'h00;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [1:0] o_kind;
    logic [7:0] o_value;
    logic       o_last;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_initial_leds = 3'b000;

    // Key layouts, indexed by the 7-bit make code.
    logic [7:0] plain_keys [0:127] = '{
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h5E, 8'h08, 8'h00,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h40, 8'h5B, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3B,
        8'h3A, 8'h00, 8'h00, 8'h5D, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h5C, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5C, 8'h00, 8'h00
    };

    logic [7:0] shifted_keys [0:127] = '{
        8'h00, 8'h00, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
        8'h27, 8'h28, 8'h29, 8'h7E, 8'h3D, 8'h7E, 8'h08, 8'h00,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h60, 8'h7B, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h2B,
        8'h2A, 8'h00, 8'h00, 8'h7D, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h5F, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7C, 8'h00, 8'h00
    };

    // Keyboard state as the decoder should see it.
    logic [2:0] cfg_leds = 3'b000;
    logic [1:0] exp_shift = 2'b00;
    logic [2:0] exp_leds = 3'b000;
    logic       key_started = 1'b0;
    logic       key_awaiting = 1'b0;
    logic [7:0] key_last_sent = 8'h00;
    logic [7:0] led_cmd_fifo[$];

    logic [7:0]  pending_codes[$];
    t_key_result expected_results[$];

    int error_count = 0;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    ps2_scancode_to_char_with_led_cmd #(
        .CMD_QUEUE_DEPTH(CMD_QUEUE_DEPTH_DEF)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_scan_code(i_scan_code),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_kind(o_kind),
        .o_value(o_value),
        .o_last(o_last),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_initial_leds(i_cfg_initial_leds)
    );

    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 100) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
    endtask

    task automatic push_led_byte(input logic [7:0] b);
        if (led_cmd_fifo.size() < CMD_QUEUE_DEPTH_DEF) begin
            led_cmd_fifo.push_back(b);
        end
    endtask

    task automatic queue_led_update();
        push_led_byte(KB_LED_CMD);
        push_led_byte({5'b00000, exp_leds});
    endtask

    // Works out the results that one scan code beat should produce.
    task automatic predict_scan_code(input logic [7:0] code);
        t_key_result res[$];
        logic [7:0]  ch;
        if (!key_started) begin
            key_started = 1'b1;
            exp_leds = cfg_leds;
            queue_led_update();
        end
        if (!code[7]) begin
            ch = (exp_shift != 2'b00) ? shifted_keys[code[6:0]] : plain_keys[code[6:0]];
            // Letters come out lowercase when caps lock and shift agree.
            if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z && exp_leds[2] == (exp_shift != 2'b00)) begin
                ch = ch + CHAR_CASE;
            end
            if (ch != 8'h00) begin
                res.push_back('{kind: KIND_CHAR, value: ch, last: 1'b0});
            end
        end
        case (code)
            SC_TAB: res.push_back('{kind: KIND_EVENT, value: EVT_TAB, last: 1'b0});
            SC_LSHIFT_MAKE: exp_shift[0] = 1'b1;
            SC_RSHIFT_MAKE: exp_shift[1] = 1'b1;
            SC_LSHIFT_BRK: exp_shift[0] = 1'b0;
            SC_RSHIFT_BRK: exp_shift[1] = 1'b0;
            SC_CAPS_LOCK: begin
                exp_leds = exp_leds ^ LED_CAPS;
                queue_led_update();
            end
            SC_NUM_LOCK: begin
                exp_leds = exp_leds ^ LED_NUM;
                queue_led_update();
            end
            SC_SCROLL_LOCK: begin
                exp_leds = exp_leds ^ LED_SCROLL;
                queue_led_update();
            end
            SC_F1: begin
                if (exp_shift != 2'b00) begin
                    res.push_back('{kind: KIND_EVENT, value: EVT_BREAK, last: 1'b0});
                end
            end
            SC_F11: res.push_back('{kind: KIND_EVENT, value: EVT_RAISE, last: 1'b0});
            KB_ACK: key_awaiting = 1'b0;
            KB_RESEND: begin
                if (key_awaiting) begin
                    res.push_back('{kind: KIND_CMD, value: key_last_sent, last: 1'b0});
                end
            end
            default: ;
        endcase
        if (led_cmd_fifo.size() != 0 && !key_awaiting) begin
            key_last_sent = led_cmd_fifo.pop_front();
            key_awaiting = 1'b1;
            res.push_back('{kind: KIND_CMD, value: key_last_sent, last: 1'b0});
        end
        if (res.size() != 0) begin
            res[res.size() - 1].last = 1'b1;
        end
        foreach (res[i]) begin
            expected_results.push_back(res[i]);
        end
    endtask

    // Appends one short, mostly well-formed stretch of keyboard traffic.
    task automatic add_key_sequence();
        int         pick;
        int         n;
        logic [7:0] code;
        logic [7:0] shift_key;
        pick = $urandom_range(99);
        if (pick < 35) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                code = 8'($urandom_range(8'h7F));
                pending_codes.push_back(code);
                if ($urandom_range(1) == 1) begin
                    pending_codes.push_back(code | 8'h80);
                end
            end
        end else if (pick < 50) begin
            shift_key = ($urandom_range(1) == 1) ? SC_LSHIFT_MAKE : SC_RSHIFT_MAKE;
            pending_codes.push_back(shift_key);
            n = $urandom_range(1, 5);
            repeat (n) begin
                pending_codes.push_back(8'($urandom_range(8'h7F)));
                if ($urandom_range(3) == 0) begin
                    pending_codes.push_back(SC_F1);
                end
            end
            pending_codes.push_back(shift_key | 8'h80);
        end else if (pick < 65) begin
            case ($urandom_range(2))
                0: code = SC_CAPS_LOCK;
                1: code = SC_NUM_LOCK;
                default: code = SC_SCROLL_LOCK;
            endcase
            pending_codes.push_back(code);
            if ($urandom_range(2) == 0) begin
                pending_codes.push_back(KB_RESEND);
            end
            pending_codes.push_back(KB_ACK);
            if ($urandom_range(3) == 0) begin
                pending_codes.push_back(KB_RESEND);
            end
            pending_codes.push_back(KB_ACK);
        end else if (pick < 75) begin
            case ($urandom_range(2))
                0: pending_codes.push_back(SC_TAB);
                1: pending_codes.push_back(SC_F11);
                default: pending_codes.push_back(SC_F1);
            endcase
        end else if (pick < 88) begin
            pending_codes.push_back(($urandom_range(1) == 1) ? KB_ACK : KB_RESEND);
        end else if (pick < 90) begin
            // Lock keys with no answers overrun the command queue; then drain it.
            n = $urandom_range(16, 20);
            repeat (n) begin
                pending_codes.push_back(($urandom_range(1) == 1) ? SC_CAPS_LOCK : SC_NUM_LOCK);
            end
            repeat (40) pending_codes.push_back(KB_ACK);
        end else begin
            n = $urandom_range(1, 3);
            repeat (n) pending_codes.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic wait_drained();
        while (pending_codes.size() != 0 || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
        // A beat with no result may still be writing LED bytes internally.
        repeat (16) @(negedge i_clk);
    endtask

    task automatic write_initial_leds(input logic [2:0] leds);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_initial_leds <= leds;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Scan code driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                void'(pending_codes.pop_front());
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_codes.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    i_in_valid <= 1'b1;
                    i_scan_code <= pending_codes[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver with random stalls and an occasional long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Monitor: tracks the register, predicts on each input beat, checks each result beat.
    always @(posedge i_clk) begin
        t_key_result exp_res;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_leds = i_cfg_initial_leds;
            end
            if (i_in_valid && o_in_ready) begin
                predict_scan_code(i_scan_code);
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind=%0d value=%02h last=%0b",
                                              o_kind, o_value, o_last));
                end else begin
                    exp_res = expected_results.pop_front();
                    if (o_kind !== exp_res.kind) begin
                        report_mismatch($sformatf("kind %0d, expected %0d", o_kind, exp_res.kind));
                    end
                    if (o_value !== exp_res.value) begin
                        report_mismatch($sformatf("value %02h, expected %02h",
                                                  o_value, exp_res.value));
                    end
                    if (o_last !== exp_res.last) begin
                        report_mismatch($sformatf("last %0b, expected %0b", o_last, exp_res.last));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Only this first value reaches the LEDs; later writes come after the first byte and never reach them.
        write_initial_leds(3'($urandom_range(7)));
        pending_codes = '{8'h1E, KB_ACK, KB_RESEND, KB_ACK, KB_ACK, KB_RESEND,
                          SC_CAPS_LOCK, KB_ACK, KB_ACK, SC_LSHIFT_MAKE, 8'h1E, SC_F1,
                          SC_RSHIFT_MAKE, SC_LSHIFT_BRK, 8'h7D, SC_RSHIFT_BRK, SC_F1,
                          SC_TAB, SC_F11, SC_NUM_LOCK, SC_SCROLL_LOCK, KB_ACK, KB_ACK,
                          KB_ACK, 8'h00, 8'h7F, 8'hFF};
        wait_drained();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    send_gap_pct = 0;
                    recv_stall_pct = 0;
                    write_initial_leds(3'b111);
                end
                1: begin
                    send_gap_pct = 84;
                    recv_stall_pct = 0;
                    write_initial_leds(3'b000);
                end
                2: begin
                    send_gap_pct = 0;
                    recv_stall_pct = 84;
                    write_initial_leds(3'($urandom_range(7)));
                end
                3: begin
                    send_gap_pct = 10;
                    recv_stall_pct = 10;
                    write_initial_leds(3'b010);
                end
                default: begin
                    send_gap_pct = 0;
                    recv_stall_pct = 0;
                    write_initial_leds(3'b101);
                    hold_token++;
                end
            endcase
            while (pending_codes.size() < 300) begin
                add_key_sequence();
            end
            wait_drained();
        end

        repeat (24) @(negedge i_clk);
        foreach (expected_results[i]) begin
            report_mismatch($sformatf("missing result kind=%0d value=%02h last=%0b",
                                      expected_results[i].kind, expected_results[i].value,
                                      expected_results[i].last));
        end
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
